### rtl/kst_pkg.sv
// kst_pkg: field widths, operation kinds and status codes of the keyed slot table.
// No dependencies; used by every file under rtl.
package kst_pkg;

   localparam int KIND_W   = 2;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 3;
   localparam int STAMP_W  = 32;
   localparam int OCC_W    = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_TOUCH  = 2'd2,
      KIND_LOOKUP = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ABSENT    = 2'd1,
      STATUS_EMPTY_KEY = 2'd2
   } status_type;

endpackage

### rtl/kst_store.sv
// kst_store: slot key/stamp storage, one write port and one registered read port.
// Per-slot valid bits are cleared by reset. Depends on kst_pkg.
module kst_store #(
   parameter  int SLOTS = 8,
   localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [IDXW-1:0]              rd_addr,
   output logic                         rd_valid,
   output logic [kst_pkg::KEY_W-1:0]    rd_key,
   output logic [kst_pkg::STAMP_W-1:0]  rd_stamp,
   input  logic                         wr_en,
   input  logic [IDXW-1:0]              wr_addr,
   input  logic                         wr_valid,
   input  logic [kst_pkg::KEY_W-1:0]    wr_key,
   input  logic [kst_pkg::STAMP_W-1:0]  wr_stamp
);

   logic [kst_pkg::KEY_W-1:0]   key_mem   [SLOTS];
   logic [kst_pkg::STAMP_W-1:0] stamp_mem [SLOTS];
   logic [SLOTS-1:0]            valid_ff;

   logic                        rd_valid_ff;
   logic [kst_pkg::KEY_W-1:0]   rd_key_ff;
   logic [kst_pkg::STAMP_W-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= wr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
      rd_key_ff   <= key_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_key   = rd_key_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

### rtl/kst_scan.sv
// kst_scan: shared compare unit, one slot per cycle while enabled: key match, first free slot, LRU slot.
// Depends on kst_pkg.
module kst_scan #(
   parameter  int SLOTS = 8,
   localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         enable,
   input  logic [IDXW-1:0]              ent_idx,
   input  logic                         ent_valid,
   input  logic [kst_pkg::KEY_W-1:0]    ent_key,
   input  logic [kst_pkg::STAMP_W-1:0]  ent_stamp,
   input  logic [kst_pkg::KEY_W-1:0]    search_key,
   output logic                         match_found,
   output logic [IDXW-1:0]              match_idx,
   output logic [kst_pkg::STAMP_W-1:0]  match_stamp,
   output logic                         free_found,
   output logic [IDXW-1:0]              free_idx,
   output logic [IDXW-1:0]              lru_idx
);

   logic                        match_found_ff, match_found_in;
   logic                        free_found_ff, free_found_in;
   logic                        lru_have_ff, lru_have_in;
   logic [IDXW-1:0]             match_idx_ff, match_idx_in;
   logic [IDXW-1:0]             free_idx_ff, free_idx_in;
   logic [IDXW-1:0]             lru_idx_ff, lru_idx_in;
   logic [kst_pkg::STAMP_W-1:0] match_stamp_ff, match_stamp_in;
   logic [kst_pkg::STAMP_W-1:0] lru_stamp_ff, lru_stamp_in;
   logic                        key_eq;
   logic                        stamp_lt;

   // the shared compare unit
   assign key_eq   = (ent_key == search_key);
   assign stamp_lt = (ent_stamp < lru_stamp_ff);

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_stamp_in = match_stamp_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      lru_have_in    = lru_have_ff;
      lru_idx_in     = lru_idx_ff;
      lru_stamp_in   = lru_stamp_ff;
      if (clear) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         lru_have_in    = 1'b0;
      end else if (enable) begin
         if (!match_found_ff && ent_valid && key_eq) begin
            match_found_in = 1'b1;
            match_idx_in   = ent_idx;
            match_stamp_in = ent_stamp;
         end
         if (!free_found_ff && !ent_valid) begin
            free_found_in = 1'b1;
            free_idx_in   = ent_idx;
         end
         // strict less-than keeps the lowest index on ties
         if (ent_valid && (!lru_have_ff || stamp_lt)) begin
            lru_have_in  = 1'b1;
            lru_idx_in   = ent_idx;
            lru_stamp_in = ent_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         lru_have_ff    <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         lru_have_ff    <= lru_have_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff   <= match_idx_in;
      match_stamp_ff <= match_stamp_in;
      free_idx_ff    <= free_idx_in;
      lru_idx_ff     <= lru_idx_in;
      lru_stamp_ff   <= lru_stamp_in;
   end

   assign match_found = match_found_ff;
   assign match_idx   = match_idx_ff;
   assign match_stamp = match_stamp_ff;
   assign free_found  = free_found_ff;
   assign free_idx    = free_idx_ff;
   assign lru_idx     = lru_idx_ff;

endmodule

### rtl/keyed_slot_table_lru_top.sv
// keyed_slot_table_lru_top: fully associative keyed slot table with use-stamp LRU replacement.
// Requests are taken only while idle, so one item runs at a time; the slot scan reads one entry
//   per cycle through the single registered read port of kst_store into the shared compare unit.
//   An empty key skips the scan and goes straight to the finish step.
// Reset (synchronous): all slots empty, use counter and occupied count zero; no clearing pass.
// Depends on kst_pkg, kst_store, kst_scan.
module keyed_slot_table_lru_top #(
   parameter int SLOTS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [kst_pkg::KIND_W-1:0]     req_kind,
   input  logic [kst_pkg::KEY_W-1:0]      req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [kst_pkg::STATUS_W-1:0]   rsp_status,
   output logic [kst_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [kst_pkg::STAMP_W-1:0]    rsp_stamp,
   output logic [kst_pkg::OCC_W-1:0]      rsp_occupied
);

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNTW = $clog2(SLOTS + 1);   // holds 0..SLOTS

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // item registers
   kst_pkg::kind_type           kind_ff, kind_in;
   logic [kst_pkg::KEY_W-1:0]   key_ff, key_in;

   // scan sequencer: issue counter and read-pending stage
   logic [CNTW-1:0]             iss_ff, iss_in;
   logic                        pend_ff, pend_in;
   logic [IDXW-1:0]             pend_idx_ff, pend_idx_in;
   logic                        issuing;

   // table-wide state
   logic [kst_pkg::STAMP_W-1:0] ctr_ff, ctr_in;
   logic [CNTW-1:0]             occ_ff, occ_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [kst_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [kst_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [kst_pkg::STAMP_W-1:0]   rsp_stamp_ff, rsp_stamp_in;
   logic [kst_pkg::OCC_W-1:0]     rsp_occ_ff, rsp_occ_in;

   logic                        req_xfer;
   logic                        can_load;
   logic                        fin_go;

   // store and scan unit connections
   logic [IDXW-1:0]             rd_addr;
   logic                        rd_valid;
   logic [kst_pkg::KEY_W-1:0]   rd_key;
   logic [kst_pkg::STAMP_W-1:0] rd_stamp;
   logic                        wr_en;
   logic [IDXW-1:0]             wr_addr;
   logic                        wr_valid;
   logic [kst_pkg::STAMP_W-1:0] wr_stamp;
   logic                        match_found;
   logic [IDXW-1:0]             match_idx;
   logic [kst_pkg::STAMP_W-1:0] match_stamp;
   logic                        free_found;
   logic [IDXW-1:0]             free_idx;
   logic [IDXW-1:0]             lru_idx;

   // result composition
   logic [IDXW-1:0]             ins_idx;
   logic [kst_pkg::STAMP_W-1:0] ctr_next;
   logic [31:0]                 slot_wide;
   logic [31:0]                 occ_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign fin_go    = (state_ff == ST_FIN) && can_load;
   assign issuing   = (state_ff == ST_SCAN) && (iss_ff < CNTW'(SLOTS));
   assign rd_addr   = issuing ? iss_ff[IDXW-1:0] : '0;
   assign ctr_next  = ctr_ff + 32'd1;

   // insert target: matching slot, else lowest free slot, else LRU slot
   always_comb begin
      priority if (match_found) begin
         ins_idx = match_idx;
      end else if (free_found) begin
         ins_idx = free_idx;
      end else begin
         ins_idx = lru_idx;
      end
   end

   kst_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_valid (rd_valid),
      .rd_key   (rd_key),
      .rd_stamp (rd_stamp),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_valid (wr_valid),
      .wr_key   (key_ff),
      .wr_stamp (wr_stamp)
   );

   kst_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (req_xfer),
      .enable      (pend_ff),
      .ent_idx     (pend_idx_ff),
      .ent_valid   (rd_valid),
      .ent_key     (rd_key),
      .ent_stamp   (rd_stamp),
      .search_key  (key_ff),
      .match_found (match_found),
      .match_idx   (match_idx),
      .match_stamp (match_stamp),
      .free_found  (free_found),
      .free_idx    (free_idx),
      .lru_idx     (lru_idx)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      iss_in      = iss_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               kind_in  = kst_pkg::kind_type'(req_kind);
               key_in   = req_key;
               iss_in   = '0;
               // empty key skips the scan
               state_in = (req_key == '0) ? ST_FIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               iss_in      = iss_ff + CNTW'(1);
               pend_in     = 1'b1;
               pend_idx_in = iss_ff[IDXW-1:0];
            end else begin
               // last entry is evaluated at this edge
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // finish: table write, counter, occupied count and result
   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = match_idx;
      wr_valid      = 1'b1;
      wr_stamp      = ctr_next;
      ctr_in        = ctr_ff;
      occ_in        = occ_ff;
      rsp_status_in = kst_pkg::STATUS_OK;
      slot_wide     = '0;
      rsp_stamp_in  = '0;
      if (key_ff == '0) begin
         rsp_status_in = kst_pkg::STATUS_EMPTY_KEY;
      end else if (kind_ff == kst_pkg::KIND_INSERT) begin
         wr_en        = fin_go;
         wr_addr      = ins_idx;
         slot_wide    = 32'(ins_idx);
         rsp_stamp_in = ctr_next;
         if (fin_go) begin
            ctr_in = ctr_next;
            if (!match_found && free_found) begin
               occ_in = occ_ff + CNTW'(1);
            end
         end
      end else if (!match_found) begin
         rsp_status_in = kst_pkg::STATUS_ABSENT;
      end else begin
         slot_wide = 32'(match_idx);
         unique case (kind_ff)
            kst_pkg::KIND_REMOVE: begin
               wr_en    = fin_go;
               wr_valid = 1'b0;
               wr_stamp = '0;
               if (fin_go) begin
                  occ_in = occ_ff - CNTW'(1);
               end
            end
            kst_pkg::KIND_TOUCH: begin
               wr_en        = fin_go;
               rsp_stamp_in = ctr_next;
               if (fin_go) begin
                  ctr_in = ctr_next;
               end
            end
            default: begin
               // lookup
               rsp_stamp_in = match_stamp;
            end
         endcase
      end
      occ_wide    = 32'(occ_in);
      rsp_slot_in = slot_wide[kst_pkg::SLOT_W-1:0];
      rsp_occ_in  = occ_wide[kst_pkg::OCC_W-1:0];
   end

   // result register parts the two sides
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         ctr_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         ctr_ff       <= ctr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      pend_idx_ff <= pend_idx_in;
      if (fin_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_stamp_ff  <= rsp_stamp_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_stamp    = rsp_stamp_ff;
   assign rsp_occupied = rsp_occ_ff;

   // occupied count never exceeds the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNTW'(SLOTS))
      else $error("occupied count above SLOTS");

   // occupied count and use counter only move at the finish step
   a_occ_fin: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ((occ_ff != $past(occ_ff)) || (ctr_ff != $past(ctr_ff))))
      |-> $past(fin_go))
      else $error("table state changed outside finish step");

   // a new result only appears after a finish step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ST_FIN))
      else $error("result raised without finish step");

   // scan reads stay inside the table, one per cycle after the first
   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      issuing |-> (iss_ff < CNTW'(SLOTS)) && (pend_ff || (iss_ff == '0)))
      else $error("scan read out of range");

endmodule
